>>> design/mflg_pkg.sv
// Shared constants for the level-graph maximum flow core.
// No dependencies; used by max_flow_level_graph_core.
package mflg_pkg;

    // Default sizes of the node table, arc store and capacity word
    localparam int NODES_DEF    = 64;
    localparam int ARCS_DEF     = 512;
    localparam int CAP_BITS_DEF = 32;

    // Fixed field widths
    localparam int NODE_FIELD_W = 6;
    localparam int CFG_W        = 32;
    localparam int FLOW_W       = 40;
    localparam int STATUS_W     = 2;

    // Command codes
    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_RUN = 1'b1;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SAME = 2'd2;

endpackage

>>> design/max_flow_level_graph_core.sv
// Maximum flow core: arc store, level-graph build and blocking-flow search.
// Depends on mflg_pkg for sizes, command and status codes.
//
// Edge pairs are loaded one transaction at a time and a run transaction returns the maximum
// flow from source to sink over the residual graph; residual capacities persist across runs.
// An add walks the sequencer through S_A0 to S_A3 and hands over the result in S_DONE, so
// a new transaction is accepted only once the add is through. A run is walked by one small
// sequencer over single-port-read memories: each phase clears the level marks and seeds the
// queue with the source, scans the arcs of each queued node in the breadth-first pass, then
// clears the cursor marks and searches the level graph, trying arcs and retreating from
// dead ends, and finds and applies the bottleneck of each path that reaches the sink. The
// run time therefore grows with phases and arcs. s_ready is high only while the sequencer
// is idle; a finished result waits in the output register without blocking the next
// transaction. No clearing pass is needed after reset.
module max_flow_level_graph_core #(
    parameter int NODES    = mflg_pkg::NODES_DEF,
    parameter int ARCS     = mflg_pkg::ARCS_DEF,
    parameter int CAP_BITS = mflg_pkg::CAP_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // configuration write channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mflg_pkg::CFG_W-1:0]       cfg_data,
    // input channel
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_cmd,
    input  logic [mflg_pkg::NODE_FIELD_W-1:0] s_edge_from,
    input  logic [mflg_pkg::NODE_FIELD_W-1:0] s_edge_to,
    input  logic [31:0]                      s_cap_forward,
    input  logic [31:0]                      s_cap_backward,
    input  logic [mflg_pkg::NODE_FIELD_W-1:0] s_source,
    input  logic [mflg_pkg::NODE_FIELD_W-1:0] s_sink,
    // result channel
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [mflg_pkg::STATUS_W-1:0]    m_status,
    output logic [mflg_pkg::FLOW_W-1:0]      m_flow_total
);

    localparam int NW  = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int AAW = (ARCS > 1) ? $clog2(ARCS) : 1;
    localparam int AW  = $clog2(ARCS + 1);
    localparam int DW  = $clog2(NODES + 1);
    localparam int CB  = CAP_BITS;
    localparam int BW  = (CB > mflg_pkg::CFG_W) ? CB : mflg_pkg::CFG_W;
    localparam int CSW = BW + 1;
    localparam int SW  = (BW + 1 > mflg_pkg::FLOW_W + 1) ? BW + 1 : mflg_pkg::FLOW_W + 1;
    localparam int FW  = mflg_pkg::FLOW_W;

    localparam logic [AW-1:0]  ARC_NULL = AW'(ARCS);
    localparam logic [CB-1:0]  CAP_MAX  = {CB{1'b1}};
    localparam logic [FW-1:0]  FLOW_MAX = {FW{1'b1}};

    // sequencer codes
    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_A0    = 5'd1;
    localparam logic [4:0] S_A1    = 5'd2;
    localparam logic [4:0] S_A2    = 5'd3;
    localparam logic [4:0] S_A3    = 5'd4;
    localparam logic [4:0] S_BINIT = 5'd5;
    localparam logic [4:0] S_BDEQ  = 5'd6;
    localparam logic [4:0] S_BD    = 5'd7;
    localparam logic [4:0] S_BD2   = 5'd8;
    localparam logic [4:0] S_BARC  = 5'd9;
    localparam logic [4:0] S_BARC2 = 5'd10;
    localparam logic [4:0] S_BEND  = 5'd11;
    localparam logic [4:0] S_GTOP  = 5'd12;
    localparam logic [4:0] S_GCUR  = 5'd13;
    localparam logic [4:0] S_GARC  = 5'd14;
    localparam logic [4:0] S_GARC2 = 5'd15;
    localparam logic [4:0] S_GPOP  = 5'd16;
    localparam logic [4:0] S_GPOP2 = 5'd17;
    localparam logic [4:0] S_GPOP3 = 5'd18;
    localparam logic [4:0] S_GPOP4 = 5'd19;
    localparam logic [4:0] S_PMIN  = 5'd20;
    localparam logic [4:0] S_PMIN1 = 5'd21;
    localparam logic [4:0] S_PMIN2 = 5'd22;
    localparam logic [4:0] S_PCHK  = 5'd23;
    localparam logic [4:0] S_PUPD  = 5'd24;
    localparam logic [4:0] S_PU1   = 5'd25;
    localparam logic [4:0] S_PU2   = 5'd26;
    localparam logic [4:0] S_PU3   = 5'd27;
    localparam logic [4:0] S_DONE  = 5'd28;

    // memories
    logic [NW-1:0]  tgt_mem [ARCS];
    logic [CB-1:0]  cap_mem [ARCS];
    logic [AAW-1:0] ptn_mem [ARCS];
    logic [AW-1:0]  nxt_mem [ARCS];
    logic [AW-1:0]  first_mem [NODES];
    logic [AW-1:0]  last_mem [NODES];
    logic [NW-1:0]  lvl_mem [NODES];
    logic [AW-1:0]  cur_mem [NODES];
    logic [NW-1:0]  que_mem [NODES];
    logic [AAW-1:0] stk_mem [NODES];

    logic [NW-1:0]  tgt_rd;
    logic [CB-1:0]  cap_rd;
    logic [AAW-1:0] ptn_rd;
    logic [AW-1:0]  nxt_rd;
    logic [AW-1:0]  first_rd, last_rd, cur_rd;
    logic [NW-1:0]  lvl_rd, que_rd;
    logic [AAW-1:0] stk_rd;

    logic [AAW-1:0] arc_ra;
    logic [NW-1:0]  node_ra, que_ra, stk_ra;

    logic           tgt_we, cap_we, ptn_we, nxt_we;
    logic [AAW-1:0] tgt_wa, cap_wa, ptn_wa, nxt_wa;
    logic [NW-1:0]  tgt_wd;
    logic [CB-1:0]  cap_wd;
    logic [AAW-1:0] ptn_wd;
    logic [AW-1:0]  nxt_wd;
    logic           first_we, last_we, lvl_we, cur_we, que_we, stk_we;
    logic [NW-1:0]  first_wa, last_wa, lvl_wa, cur_wa, que_wa, stk_wa;
    logic [AW-1:0]  first_wd, last_wd, cur_wd;
    logic [NW-1:0]  lvl_wd, que_wd;
    logic [AAW-1:0] stk_wd;

    // registers
    logic [4:0]          state_reg, state_next;
    logic [AW-1:0]       arc_count_reg, arc_count_next;
    logic [NODES-1:0]    first_vld_reg, first_vld_next;
    logic [NODES-1:0]    lvl_vld_reg, lvl_vld_next;
    logic [NODES-1:0]    cur_vld_reg, cur_vld_next;
    logic [DW-1:0]       head_reg, head_next, tail_reg, tail_next;
    logic [DW-1:0]       depth_reg, depth_next, idx_reg, idx_next;
    logic [NW-1:0]       v_reg, v_next, d_reg, d_next;
    logic [NW-1:0]       src_reg, src_next, snk_reg, snk_next;
    logic [NW-1:0]       lvl_v_reg, lvl_v_next, lvl_d_reg, lvl_d_next;
    logic [AW-1:0]       a_reg, a_next, nxt_hold_reg, nxt_hold_next;
    logic [AAW-1:0]      r_reg, r_next;
    logic [BW-1:0]       bn_reg, bn_next;
    logic [FW-1:0]       flow_reg, flow_next;
    logic                phase_reg, phase_next;
    logic [CB-1:0]       capf_reg, capf_next, capb_reg, capb_next;
    logic [mflg_pkg::STATUS_W-1:0] status_reg, status_next;
    logic [mflg_pkg::CFG_W-1:0]    limit_reg, limit_next;
    logic                m_valid_reg, m_valid_next;
    logic [mflg_pkg::STATUS_W-1:0] m_status_reg, m_status_next;
    logic [FW-1:0]       m_flow_reg, m_flow_next;

    // combinational helpers
    logic [AW-1:0]  a_sel;
    logic           step_ok;
    logic [SW-1:0]  flow_sum;
    logic [CSW-1:0] cap_sum;

    // arc store: one write and one registered read per memory
    always_ff @(posedge aclk) begin
        if (tgt_we) tgt_mem[tgt_wa] <= tgt_wd;
        if (cap_we) cap_mem[cap_wa] <= cap_wd;
        if (ptn_we) ptn_mem[ptn_wa] <= ptn_wd;
        if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
        tgt_rd <= tgt_mem[arc_ra];
        cap_rd <= cap_mem[arc_ra];
        ptn_rd <= ptn_mem[arc_ra];
        nxt_rd <= nxt_mem[arc_ra];
    end

    // node tables, visit queue and path stack
    always_ff @(posedge aclk) begin
        if (first_we) first_mem[first_wa] <= first_wd;
        if (last_we)  last_mem[last_wa]   <= last_wd;
        if (lvl_we)   lvl_mem[lvl_wa]     <= lvl_wd;
        if (cur_we)   cur_mem[cur_wa]     <= cur_wd;
        if (que_we)   que_mem[que_wa]     <= que_wd;
        if (stk_we)   stk_mem[stk_wa]     <= stk_wd;
        first_rd <= first_mem[node_ra];
        last_rd  <= last_mem[node_ra];
        lvl_rd   <= lvl_mem[node_ra];
        cur_rd   <= cur_mem[node_ra];
        que_rd   <= que_mem[que_ra];
        stk_rd   <= stk_mem[stk_ra];
    end

    assign cfg_ready    = 1'b1;
    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_flow_total = m_flow_reg;

    // cursor of the current node: written cursor, else the first arc, else none
    assign a_sel = cur_vld_reg[v_reg] ? cur_rd :
                   (first_vld_reg[v_reg] ? first_rd : ARC_NULL);

    // admissible arc test for the search
    assign step_ok = (cap_rd != '0) && lvl_vld_reg[v_reg] && lvl_vld_reg[tgt_rd] &&
                     ({1'b0, lvl_rd} == ({1'b0, lvl_v_reg} + 1'b1)) &&
                     (32'(depth_reg) < NODES);

    assign flow_sum = SW'(flow_reg) + SW'(bn_reg);
    assign cap_sum  = CSW'(cap_rd) + CSW'(bn_reg);

    // sequencer
    always_comb begin
        state_next     = state_reg;
        arc_count_next = arc_count_reg;
        first_vld_next = first_vld_reg;
        lvl_vld_next   = lvl_vld_reg;
        cur_vld_next   = cur_vld_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        depth_next     = depth_reg;
        idx_next       = idx_reg;
        v_next         = v_reg;
        d_next         = d_reg;
        src_next       = src_reg;
        snk_next       = snk_reg;
        lvl_v_next     = lvl_v_reg;
        lvl_d_next     = lvl_d_reg;
        a_next         = a_reg;
        nxt_hold_next  = nxt_hold_reg;
        r_next         = r_reg;
        bn_next        = bn_reg;
        flow_next      = flow_reg;
        phase_next     = phase_reg;
        capf_next      = capf_reg;
        capb_next      = capb_reg;
        status_next    = status_reg;
        limit_next     = limit_reg;
        m_valid_next   = m_valid_reg;
        m_status_next  = m_status_reg;
        m_flow_next    = m_flow_reg;

        arc_ra  = a_reg[AAW-1:0];
        node_ra = v_reg;
        que_ra  = head_reg[NW-1:0];
        stk_ra  = idx_reg[NW-1:0];

        tgt_we = 1'b0; tgt_wa = arc_count_reg[AAW-1:0]; tgt_wd = snk_reg;
        cap_we = 1'b0; cap_wa = arc_count_reg[AAW-1:0]; cap_wd = capf_reg;
        ptn_we = 1'b0; ptn_wa = arc_count_reg[AAW-1:0]; ptn_wd = arc_count_reg[AAW-1:0];
        nxt_we = 1'b0; nxt_wa = arc_count_reg[AAW-1:0]; nxt_wd = ARC_NULL;
        first_we = 1'b0; first_wa = src_reg; first_wd = arc_count_reg;
        last_we  = 1'b0; last_wa  = src_reg; last_wd  = arc_count_reg;
        lvl_we   = 1'b0; lvl_wa   = src_reg; lvl_wd   = '0;
        cur_we   = 1'b0; cur_wa   = v_reg;   cur_wd   = nxt_rd;
        que_we   = 1'b0; que_wa   = tail_reg[NW-1:0]; que_wd = src_reg;
        stk_we   = 1'b0; stk_wa   = depth_reg[NW-1:0]; stk_wd = a_reg[AAW-1:0];

        // config register
        if (cfg_valid) limit_next = cfg_data;

        // drop the result once taken
        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    flow_next   = '0;
                    status_next = mflg_pkg::ST_OK;
                    if (s_cmd == mflg_pkg::CMD_ADD) begin
                        src_next  = NW'(s_edge_from);
                        snk_next  = NW'(s_edge_to);
                        capf_next = CB'(s_cap_forward);
                        capb_next = CB'(s_cap_backward);
                        if (32'(s_edge_from) >= NODES || 32'(s_edge_to) >= NODES ||
                            32'(arc_count_reg) + 32'd2 > ARCS) begin
                            status_next = mflg_pkg::ST_FULL;
                            state_next  = S_DONE;
                        end else begin
                            state_next = S_A0;
                        end
                    end else begin
                        src_next = NW'(s_source);
                        snk_next = NW'(s_sink);
                        if (s_source == s_sink || 32'(s_source) >= NODES ||
                            32'(s_sink) >= NODES) begin
                            status_next = mflg_pkg::ST_SAME;
                            state_next  = S_DONE;
                        end else begin
                            state_next = S_BINIT;
                        end
                    end
                end
            end

            // forward arc, fetch tail's last arc
            S_A0: begin
                tgt_we = 1'b1; tgt_wd = snk_reg;
                cap_we = 1'b1; cap_wd = capf_reg;
                ptn_we = 1'b1; ptn_wd = AAW'(arc_count_reg + 1'b1);
                nxt_we = 1'b1; nxt_wd = ARC_NULL;
                node_ra    = src_reg;
                state_next = S_A1;
            end

            // link forward arc into the tail's list
            S_A1: begin
                if (first_vld_reg[src_reg]) begin
                    nxt_we = 1'b1; nxt_wa = last_rd[AAW-1:0]; nxt_wd = arc_count_reg;
                end else begin
                    first_we = 1'b1; first_wa = src_reg; first_wd = arc_count_reg;
                    first_vld_next[src_reg] = 1'b1;
                end
                last_we = 1'b1; last_wa = src_reg; last_wd = arc_count_reg;
                state_next = S_A2;
            end

            // backward arc, fetch head's last arc
            S_A2: begin
                tgt_we = 1'b1; tgt_wa = AAW'(arc_count_reg + 1'b1); tgt_wd = src_reg;
                cap_we = 1'b1; cap_wa = AAW'(arc_count_reg + 1'b1); cap_wd = capb_reg;
                ptn_we = 1'b1; ptn_wa = AAW'(arc_count_reg + 1'b1);
                ptn_wd = arc_count_reg[AAW-1:0];
                nxt_we = 1'b1; nxt_wa = AAW'(arc_count_reg + 1'b1); nxt_wd = ARC_NULL;
                node_ra    = snk_reg;
                state_next = S_A3;
            end

            // link backward arc into the head's list
            S_A3: begin
                if (first_vld_reg[snk_reg]) begin
                    nxt_we = 1'b1; nxt_wa = last_rd[AAW-1:0];
                    nxt_wd = arc_count_reg + 1'b1;
                end else begin
                    first_we = 1'b1; first_wa = snk_reg; first_wd = arc_count_reg + 1'b1;
                    first_vld_next[snk_reg] = 1'b1;
                end
                last_we = 1'b1; last_wa = snk_reg; last_wd = arc_count_reg + 1'b1;
                arc_count_next = arc_count_reg + AW'(2);
                state_next     = S_DONE;
            end

            // start a phase: clear levels, seed the queue with the source
            S_BINIT: begin
                lvl_vld_next          = '0;
                lvl_vld_next[src_reg] = 1'b1;
                lvl_we = 1'b1; lvl_wa = src_reg; lvl_wd = '0;
                que_we = 1'b1; que_wa = '0; que_wd = src_reg;
                head_next  = '0;
                tail_next  = DW'(1);
                state_next = S_BDEQ;
            end

            S_BDEQ: begin
                if (head_reg == tail_reg) begin
                    state_next = S_BEND;
                end else begin
                    head_next  = head_reg + 1'b1;
                    state_next = S_BD;
                end
            end

            S_BD: begin
                d_next     = que_rd;
                node_ra    = que_rd;
                state_next = S_BD2;
            end

            S_BD2: begin
                lvl_d_next = lvl_rd;
                a_next     = first_vld_reg[d_reg] ? first_rd : ARC_NULL;
                state_next = S_BARC;
            end

            S_BARC: begin
                state_next = (a_reg == ARC_NULL) ? S_BDEQ : S_BARC2;
            end

            // reach the arc's head if it has room and is new
            S_BARC2: begin
                if (cap_rd != '0 && !lvl_vld_reg[tgt_rd] && 32'(tail_reg) < NODES) begin
                    lvl_vld_next[tgt_rd] = 1'b1;
                    lvl_we = 1'b1; lvl_wa = tgt_rd; lvl_wd = lvl_d_reg + 1'b1;
                    que_we = 1'b1; que_wa = tail_reg[NW-1:0]; que_wd = tgt_rd;
                    tail_next = tail_reg + 1'b1;
                end
                a_next     = nxt_rd;
                state_next = S_BARC;
            end

            S_BEND: begin
                if (lvl_vld_reg[snk_reg]) begin
                    cur_vld_next = '0;
                    v_next       = src_reg;
                    lvl_v_next   = '0;
                    depth_next   = '0;
                    phase_next   = 1'b0;
                    state_next   = S_GTOP;
                end else begin
                    state_next = S_DONE;
                end
            end

            S_GTOP: begin
                if (v_reg == snk_reg) begin
                    bn_next    = BW'(limit_reg);
                    idx_next   = '0;
                    state_next = S_PMIN;
                end else begin
                    state_next = S_GCUR;
                end
            end

            // take the cursor arc, or retreat when the node is exhausted
            S_GCUR: begin
                if (a_sel == ARC_NULL) begin
                    if (depth_reg == '0) begin
                        state_next = phase_reg ? S_BINIT : S_DONE;
                    end else begin
                        depth_next = depth_reg - 1'b1;
                        stk_ra     = NW'(depth_reg - 1'b1);
                        state_next = S_GPOP;
                    end
                end else begin
                    a_next     = a_sel;
                    arc_ra     = a_sel[AAW-1:0];
                    state_next = S_GARC;
                end
            end

            S_GARC: begin
                node_ra    = tgt_rd;
                state_next = S_GARC2;
            end

            // advance along the arc or step the cursor
            S_GARC2: begin
                if (step_ok) begin
                    stk_we = 1'b1; stk_wa = depth_reg[NW-1:0]; stk_wd = a_reg[AAW-1:0];
                    depth_next = depth_reg + 1'b1;
                    v_next     = tgt_rd;
                    lvl_v_next = lvl_rd;
                end else begin
                    cur_we = 1'b1; cur_wa = v_reg; cur_wd = nxt_rd;
                    cur_vld_next[v_reg] = 1'b1;
                end
                state_next = S_GTOP;
            end

            S_GPOP: begin
                arc_ra     = stk_rd;
                state_next = S_GPOP2;
            end

            S_GPOP2: begin
                nxt_hold_next = nxt_rd;
                arc_ra        = ptn_rd;
                state_next    = S_GPOP3;
            end

            // back at the arc's tail: move its cursor past the dead arc
            S_GPOP3: begin
                v_next = tgt_rd;
                cur_we = 1'b1; cur_wa = tgt_rd; cur_wd = nxt_hold_reg;
                cur_vld_next[tgt_rd] = 1'b1;
                node_ra    = tgt_rd;
                state_next = S_GPOP4;
            end

            S_GPOP4: begin
                lvl_v_next = lvl_rd;
                state_next = S_GTOP;
            end

            // bottleneck over the path stack
            S_PMIN: begin
                state_next = (idx_reg == depth_reg) ? S_PCHK : S_PMIN1;
            end

            S_PMIN1: begin
                arc_ra     = stk_rd;
                state_next = S_PMIN2;
            end

            S_PMIN2: begin
                if (BW'(cap_rd) < bn_reg) bn_next = BW'(cap_rd);
                idx_next   = idx_reg + 1'b1;
                state_next = S_PMIN;
            end

            S_PCHK: begin
                if (bn_reg == '0) begin
                    state_next = phase_reg ? S_BINIT : S_DONE;
                end else begin
                    idx_next   = '0;
                    state_next = S_PUPD;
                end
            end

            // apply the bottleneck, then restart from the source
            S_PUPD: begin
                if (idx_reg == depth_reg) begin
                    flow_next  = (flow_sum > SW'(FLOW_MAX)) ? FLOW_MAX : FW'(flow_sum);
                    phase_next = 1'b1;
                    v_next     = src_reg;
                    lvl_v_next = '0;
                    depth_next = '0;
                    state_next = S_GTOP;
                end else begin
                    state_next = S_PU1;
                end
            end

            S_PU1: begin
                arc_ra     = stk_rd;
                state_next = S_PU2;
            end

            S_PU2: begin
                cap_we = 1'b1; cap_wa = stk_rd; cap_wd = cap_rd - CB'(bn_reg);
                r_next     = ptn_rd;
                arc_ra     = ptn_rd;
                state_next = S_PU3;
            end

            S_PU3: begin
                cap_we = 1'b1; cap_wa = r_reg;
                cap_wd = (cap_sum > CSW'(CAP_MAX)) ? CAP_MAX : CB'(cap_sum);
                idx_next   = idx_reg + 1'b1;
                state_next = S_PUPD;
            end

            // hand the result to the output register
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_flow_next   = (status_reg == mflg_pkg::ST_OK) ? flow_reg : '0;
                    state_next    = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            arc_count_reg <= '0;
            first_vld_reg <= '0;
            lvl_vld_reg   <= '0;
            cur_vld_reg   <= '0;
            head_reg      <= '0;
            tail_reg      <= '0;
            depth_reg     <= '0;
            idx_reg       <= '0;
            phase_reg     <= 1'b0;
            flow_reg      <= '0;
            limit_reg     <= '1;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            arc_count_reg <= arc_count_next;
            first_vld_reg <= first_vld_next;
            lvl_vld_reg   <= lvl_vld_next;
            cur_vld_reg   <= cur_vld_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            depth_reg     <= depth_next;
            idx_reg       <= idx_next;
            phase_reg     <= phase_next;
            flow_reg      <= flow_next;
            limit_reg     <= limit_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        v_reg        <= v_next;
        d_reg        <= d_next;
        src_reg      <= src_next;
        snk_reg      <= snk_next;
        lvl_v_reg    <= lvl_v_next;
        lvl_d_reg    <= lvl_d_next;
        a_reg        <= a_next;
        nxt_hold_reg <= nxt_hold_next;
        r_reg        <= r_next;
        bn_reg       <= bn_next;
        capf_reg     <= capf_next;
        capb_reg     <= capb_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        m_flow_reg   <= m_flow_next;
    end

    // an accepted transaction always takes the sequencer out of idle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted twice in a row");

    // a new result only appears from the hand-over state
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == S_DONE))
        else $error("result raised outside hand-over");

    // the arc store fills in pairs and never overflows
    a_arc_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (arc_count_reg[0] == 1'b0) && (32'(arc_count_reg) <= ARCS))
        else $error("arc count out of range");

    // the path stack never grows past the node count
    a_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (32'(depth_reg) <= NODES) && (32'(tail_reg) <= NODES))
        else $error("search depth out of range");

endmodule

>>> tb/max_flow_level_graph_core_test.sv
// Self-checking testbench for max_flow_level_graph_core: directed and random edge loads
// and flow runs over several path limits, checked against an in-bench flow predictor.
// Depends on mflg_pkg and the core RTL only.
module max_flow_level_graph_core_test;

    localparam int     NODE_N    = mflg_pkg::NODES_DEF;
    localparam int     ARC_N     = mflg_pkg::ARCS_DEF;
    localparam int     ARC_NIL   = mflg_pkg::ARCS_DEF;
    localparam int     NO_LEVEL  = -1;
    localparam longint CAP_TOP   = 64'hFFFF_FFFF;
    localparam longint FLOW_TOP  = (64'd1 << mflg_pkg::FLOW_W) - 1;
    localparam longint CYCLE_CAP = 64'd400_000_000;

    typedef struct {
        logic        cmd;
        logic [5:0]  from_node;
        logic [5:0]  to_node;
        logic [31:0] cap_fwd;
        logic [31:0] cap_bwd;
        logic [5:0]  src_node;
        logic [5:0]  dst_node;
    } flow_req_t;

    typedef struct {
        logic [mflg_pkg::STATUS_W-1:0] status;
        logic [mflg_pkg::FLOW_W-1:0]   flow;
    } flow_resp_t;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [mflg_pkg::CFG_W-1:0]    cfg_data;
    logic                          s_valid;
    logic                          s_ready;
    logic                          s_cmd;
    logic [5:0]                    s_edge_from;
    logic [5:0]                    s_edge_to;
    logic [31:0]                   s_cap_forward;
    logic [31:0]                   s_cap_backward;
    logic [5:0]                    s_source;
    logic [5:0]                    s_sink;
    logic                          m_valid;
    logic                          m_ready;
    logic [mflg_pkg::STATUS_W-1:0] m_status;
    logic [mflg_pkg::FLOW_W-1:0]   m_flow_total;

    flow_req_t  pending_reqs[$];
    flow_resp_t expected_resps[$];
    int         error_count = 0;
    bit         calm_mode = 0;
    bit         long_hold_req = 0;
    bit         req_active = 0;
    longint     cycle_count = 0;

    // predictor copy of the graph and register
    logic [5:0]  arc_head[ARC_N];
    logic [31:0] arc_cap[ARC_N];
    int          arc_mate[ARC_N];
    int          arc_link[ARC_N];
    int          list_first[NODE_N];
    int          list_last[NODE_N];
    int          stored_arcs;
    int          node_depth[NODE_N];
    int          node_ptr[NODE_N];
    int          route[NODE_N];
    int          bfs_queue[NODE_N];
    logic [31:0] limit_reg;

    max_flow_level_graph_core uut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_cmd(s_cmd),
        .s_edge_from(s_edge_from), .s_edge_to(s_edge_to),
        .s_cap_forward(s_cap_forward), .s_cap_backward(s_cap_backward),
        .s_source(s_source), .s_sink(s_sink),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_status(m_status), .m_flow_total(m_flow_total)
    );

    // clock
    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // hook an arc onto the end of a node's list
    function void link_arc(int node, int a);
        arc_link[a] = ARC_NIL;
        if (list_first[node] == ARC_NIL) list_first[node] = a;
        else arc_link[list_last[node]] = a;
        list_last[node] = a;
    endfunction

    // breadth-first level marking over arcs with residual capacity
    function void mark_levels(int s);
        int head, tail, d, a, u;
        head = 0;
        tail = 0;
        for (int v = 0; v < NODE_N; v++) node_depth[v] = NO_LEVEL;
        node_depth[s] = 0;
        bfs_queue[tail++] = s;
        while (head < tail) begin
            d = bfs_queue[head++];
            a = list_first[d];
            while (a != ARC_NIL) begin
                u = arc_head[a];
                if (arc_cap[a] != 0 && node_depth[u] == NO_LEVEL && tail < NODE_N) begin
                    node_depth[u] = node_depth[d] + 1;
                    bfs_queue[tail++] = u;
                end
                a = arc_link[a];
            end
        end
    endfunction

    // find and apply one level-graph path; returns the flow pushed
    function longint push_path(int s, int t);
        int depth, v, a, u, f, r;
        longint bn, sum;
        depth = 0;
        v = s;
        forever begin
            if (v == t) begin
                bn = limit_reg;
                for (int i = 0; i < depth; i++)
                    if (longint'(arc_cap[route[i]]) < bn) bn = arc_cap[route[i]];
                if (bn == 0) return 0;
                for (int i = 0; i < depth; i++) begin
                    f = route[i];
                    r = arc_mate[f];
                    arc_cap[f] = arc_cap[f] - bn[31:0];
                    sum = longint'(arc_cap[r]) + bn;
                    arc_cap[r] = (sum > CAP_TOP) ? 32'hFFFF_FFFF : sum[31:0];
                end
                return bn;
            end
            a = node_ptr[v];
            if (a == ARC_NIL) begin
                if (depth == 0) return 0;
                depth--;
                a = route[depth];
                v = arc_head[arc_mate[a]];
                node_ptr[v] = arc_link[a];
            end else begin
                u = arc_head[a];
                if (arc_cap[a] != 0 && node_depth[v] != NO_LEVEL &&
                    node_depth[u] == node_depth[v] + 1 && depth < NODE_N) begin
                    route[depth++] = a;
                    v = u;
                end else begin
                    node_ptr[v] = arc_link[a];
                end
            end
        end
    endfunction

    // work out the response to one accepted transaction and update the graph
    function flow_resp_t predict_flow(flow_req_t rq);
        flow_resp_t rs;
        longint total, phase, d;
        int k;
        rs.status = mflg_pkg::ST_OK;
        rs.flow = '0;
        if (rq.cmd == mflg_pkg::CMD_ADD) begin
            if (stored_arcs > ARC_N - 2) begin
                rs.status = mflg_pkg::ST_FULL;
            end else begin
                k = stored_arcs;
                arc_head[k] = rq.to_node;
                arc_cap[k] = rq.cap_fwd;
                arc_mate[k] = k + 1;
                arc_head[k+1] = rq.from_node;
                arc_cap[k+1] = rq.cap_bwd;
                arc_mate[k+1] = k;
                link_arc(rq.from_node, k);
                link_arc(rq.to_node, k + 1);
                stored_arcs = k + 2;
            end
        end else if (rq.src_node == rq.dst_node) begin
            rs.status = mflg_pkg::ST_SAME;
        end else begin
            total = 0;
            forever begin
                mark_levels(rq.src_node);
                if (node_depth[rq.dst_node] == NO_LEVEL) break;
                for (int v = 0; v < NODE_N; v++) node_ptr[v] = list_first[v];
                phase = 0;
                d = push_path(rq.src_node, rq.dst_node);
                while (d != 0) begin
                    phase += d;
                    total = (FLOW_TOP - total < d) ? FLOW_TOP : total + d;
                    d = push_path(rq.src_node, rq.dst_node);
                end
                if (phase == 0) break;
            end
            rs.flow = total[mflg_pkg::FLOW_W-1:0];
        end
        return rs;
    endfunction

    // capacity mix: zero, small, all ones or anything
    function logic [31:0] pick_cap(bit mostly_zero);
        int sel;
        sel = $urandom_range(0, 15);
        if (mostly_zero && sel < 11) return '0;
        if (sel < 2) return '0;
        if (sel < 10) return $urandom_range(1, 100);
        if (sel < 12) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function flow_req_t make_add(int lo, int hi, bit small_caps);
        flow_req_t rq;
        rq.cmd = mflg_pkg::CMD_ADD;
        rq.from_node = 6'($urandom_range(lo, hi));
        rq.to_node = 6'($urandom_range(lo, hi));
        rq.cap_fwd = small_caps ? $urandom_range(0, 7) : pick_cap(0);
        rq.cap_bwd = small_caps ? $urandom_range(0, 3) : pick_cap(1);
        rq.src_node = 6'($urandom);
        rq.dst_node = 6'($urandom);
        return rq;
    endfunction

    function flow_req_t make_run(int lo, int hi);
        flow_req_t rq;
        rq.cmd = mflg_pkg::CMD_RUN;
        rq.from_node = 6'($urandom);
        rq.to_node = 6'($urandom);
        rq.cap_fwd = $urandom;
        rq.cap_bwd = $urandom;
        rq.src_node = 6'($urandom_range(lo, hi));
        rq.dst_node = ($urandom_range(0, 9) == 0) ? rq.src_node :
                      6'($urandom_range(lo, hi));
        return rq;
    endfunction

    function flow_req_t dir_add(int f, int t, logic [31:0] cf, logic [31:0] cb);
        flow_req_t rq;
        rq = make_add(0, 63, 0);
        rq.from_node = 6'(f);
        rq.to_node = 6'(t);
        rq.cap_fwd = cf;
        rq.cap_bwd = cb;
        return rq;
    endfunction

    function flow_req_t dir_run(int s, int t);
        flow_req_t rq;
        rq = make_run(0, 63);
        rq.src_node = 6'(s);
        rq.dst_node = 6'(t);
        return rq;
    endfunction

    // sender: one transaction at a time from the pending queue, with random gaps
    int        send_gap;
    flow_req_t cur_req;
    always @(posedge aclk) begin
        logic next_valid;
        if (!aresetn) begin
            s_valid <= 1'b0;
            send_gap = 0;
        end else begin
            next_valid = s_valid;
            if (s_valid && s_ready) begin
                expected_resps.push_back(predict_flow(cur_req));
                req_active = 0;
                next_valid = 1'b0;
            end
            if (!next_valid) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (pending_reqs.size() > 0) begin
                    if (!calm_mode && $urandom_range(0, 7) == 0) begin
                        send_gap = $urandom_range(0, 4);
                    end else begin
                        cur_req = pending_reqs.pop_front();
                        req_active = 1;
                        s_cmd <= cur_req.cmd;
                        s_edge_from <= cur_req.from_node;
                        s_edge_to <= cur_req.to_node;
                        s_cap_forward <= cur_req.cap_fwd;
                        s_cap_backward <= cur_req.cap_bwd;
                        s_source <= cur_req.src_node;
                        s_sink <= cur_req.dst_node;
                        next_valid = 1'b1;
                    end
                end
            end
            s_valid <= next_valid;
        end
    end

    // receiver: check each result transaction, stall in bursts or one long hold
    int stall_left;
    always @(posedge aclk) begin
        flow_resp_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_resps.size() == 0) begin
                    $display("%0t: unexpected result status=%0d flow=%0d",
                             $time, m_status, m_flow_total);
                    error_count++;
                end else begin
                    want = expected_resps.pop_front();
                    if (m_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_status);
                        error_count++;
                    end
                    if (m_flow_total !== want.flow) begin
                        $display("%0t: flow_total expected %0d actual %0d",
                                 $time, want.flow, m_flow_total);
                        error_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 0;
                stall_left = 400;
                m_ready <= 1'b0;
            end else if (!calm_mode && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 4);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_CAP) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // hold until every transaction has been answered, then let the core settle
    task automatic drain_all();
        while (pending_reqs.size() > 0 || req_active || expected_resps.size() > 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_limit(logic [31:0] value);
        @(posedge aclk);
        cfg_data <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        limit_reg = value;
    endtask

    task automatic random_batch(int count, int run_pct);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) < run_pct) pending_reqs.push_back(make_run(0, 63));
            else pending_reqs.push_back(make_add(0, 63, 0));
        end
    endtask

    // stimulus
    initial begin
        aresetn = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        s_cmd = mflg_pkg::CMD_ADD;
        s_edge_from = '0;
        s_edge_to = '0;
        s_cap_forward = '0;
        s_cap_backward = '0;
        s_source = '0;
        s_sink = '0;
        for (int v = 0; v < NODE_N; v++) begin
            list_first[v] = ARC_NIL;
            list_last[v] = ARC_NIL;
            node_depth[v] = NO_LEVEL;
        end
        stored_arcs = 0;
        limit_reg = 32'hFFFF_FFFF;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // unit path limit on a small region with small capacities
        write_limit(32'd1);
        for (int i = 0; i < 60; i++) begin
            if (i % 3 == 2) pending_reqs.push_back(make_run(32, 39));
            else pending_reqs.push_back(make_add(32, 39, 1));
        end
        drain_all();

        // zero path limit: paths exist but carry nothing
        write_limit(32'd0);
        pending_reqs.push_back(dir_run(32, 39));
        pending_reqs.push_back(dir_run(33, 38));
        drain_all();

        // directed cases at full path limit
        write_limit(32'hFFFF_FFFF);
        pending_reqs.push_back(dir_add(0, 1, 32'd10, 32'd0));
        pending_reqs.push_back(dir_add(1, 2, 32'hFFFF_FFFF, 32'd0));
        pending_reqs.push_back(dir_add(0, 2, 32'd5, 32'hFFFF_FFFF));
        pending_reqs.push_back(dir_add(3, 3, 32'd9, 32'd9));
        pending_reqs.push_back(dir_add(4, 5, 32'd0, 32'd0));
        pending_reqs.push_back(dir_add(63, 62, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        pending_reqs.push_back(dir_add(62, 0, 32'hFFFF_FFFF, 32'd0));
        pending_reqs.push_back(dir_run(0, 2));
        pending_reqs.push_back(dir_run(0, 2));
        pending_reqs.push_back(dir_run(2, 0));
        pending_reqs.push_back(dir_run(5, 5));
        pending_reqs.push_back(dir_run(3, 0));
        pending_reqs.push_back(dir_run(4, 5));
        pending_reqs.push_back(dir_run(63, 62));
        pending_reqs.push_back(dir_run(62, 63));
        pending_reqs.push_back(dir_run(63, 2));
        pending_reqs.push_back(dir_run(0, 63));
        pending_reqs.push_back(dir_run(63, 63));
        drain_all();

        // random load and runs; one long receiver hold mid-batch
        random_batch(300, 35);
        long_hold_req = 1;
        drain_all();

        // large random path limit
        write_limit($urandom_range(32'h0100_0000, 32'hFFFF_FFFE));
        random_batch(700, 20);
        drain_all();

        // back to the top limit with no idling
        write_limit(32'hFFFF_FFFF);
        calm_mode = 1;
        random_batch(870, 20);
        drain_all();
        repeat (50) @(posedge aclk);

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
